@@ design/aes_pkg.sv @@
`timescale 1ns / 1ps
package aes_pkg;

    localparam int ROUNDS      = 14;
    localparam int SCHED_WORDS = 4 * (ROUNDS + 1);
    localparam int RK_AW       = 6;

    localparam logic [2:0] REG_KEY0    = 3'd0;
    localparam logic [2:0] REG_KEY1    = 3'd1;
    localparam logic [2:0] REG_KEY2    = 3'd2;
    localparam logic [2:0] REG_KEY3    = 3'd3;
    localparam logic [2:0] REG_IV_HIGH = 3'd4;
    localparam logic [2:0] REG_IV_LOW  = 3'd5;

    typedef struct packed {
        logic [63:0] text_high;
        logic [63:0] text_low;
        logic        first_block;
    } in_item_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_EXPAND,
        ST_IDLE,
        ST_ROUND,
        ST_OUT
    } core_state_t;

    typedef enum logic [1:0] {
        KS_IDLE,
        KS_LOAD,
        KS_READ,
        KS_CALC
    } ks_state_t;

    localparam logic [7:0] SBOX [256] = '{
     8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
     8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
     8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
     8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
     8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
     8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
     8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
     8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
     8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
     8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
     8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
     8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
     8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
     8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
     8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
     8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    function automatic logic [31:0] sub_word(input logic [31:0] x);
        sub_word = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    // state is column-major: byte 0 at [127:120], row r of column c at byte 4c+r
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
            end
        end
        sub_shift = t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            x0 = xtime(a0);
            x1 = xtime(a1);
            x2 = xtime(a2);
            x3 = xtime(a3);
            t[127 - 32 * c -: 32] = {x0 ^ x1 ^ a1 ^ a2 ^ a3, a0 ^ x1 ^ x2 ^ a2 ^ a3,
                                     a0 ^ a1 ^ x2 ^ x3 ^ a3, x0 ^ a0 ^ a1 ^ a2 ^ x3};
        end
        mix = t;
    endfunction

endpackage

@@ design/aes256_ctr_cipher_core.sv @@
`timescale 1ns / 1ps
// AES-256 counter mode cipher core.
// s_ channel: one 128-bit text block per transfer; first_block reloads the
//   counter from the IV before that block. m_ channel: text XOR keystream.
// Encryption and decryption are the same operation.
// Config port: cfg_we/cfg_index/cfg_data. Indexes 0..3 are key words and
//   start a key expansion of 60 words into the round key RAM (busy while it
//   runs); 4 and 5 hold the IV. Others are ignored.
// Round keys come from the 32-bit RAM one word per cycle: the initial key
//   addition gathers four words; each of the 14 rounds after it first
//   presents its own address, then gathers its four words. The result then
//   goes into the output register.
// The core takes one block at a time; s_ready is high only in idle, which
//   follows the cycle that loads the output register.
// Reset: counter and state clear, the key schedule is expanded again from
//   the zero key; s_ready stays low until that finishes.
// A stalled receiver holds the result in the output register; the next
//   block is taken meanwhile and waits for the register to free.
module aes256_ctr_cipher_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  aes_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output aes_pkg::out_item_t   m_data,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data
);
    logic [63:0] key_reg [4];
    logic [63:0] iv_hi_reg, iv_lo_reg;
    logic [127:0] ctr_reg, ctr_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] text_reg;
    logic [127:0] rk_reg;
    logic [127:0] rk_full;
    logic [3:0]  rnd_reg, rnd_next;
    logic [2:0]  wsel_reg, wsel_next;
    logic        key_start, ks_busy;
    logic        ks_we;
    logic [aes_pkg::RK_AW-1:0] ks_addr, rd_addr;
    logic [31:0] ks_data, rd_data;
    logic [127:0] round_out;
    logic        out_valid_reg;
    aes_pkg::out_item_t out_reg;
    aes_pkg::core_state_t state_reg, state_next;
    logic        accept;

    assign key_start = cfg_we && (cfg_index <= aes_pkg::REG_KEY3);

    aes_keysched u_ks (
        .aclk(aclk), .aresetn(aresetn), .start(key_start),
        .key({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .busy(ks_busy), .wr_en(ks_we), .wr_addr(ks_addr), .wr_data(ks_data)
    );

    // read address: round*4 + word select
    assign rd_addr = aes_pkg::RK_AW'({rnd_reg, 2'b00}) + aes_pkg::RK_AW'(wsel_reg[1:0]);

    aes_ram #(.WIDTH(32), .DEPTH(2 ** aes_pkg::RK_AW)) u_rk (
        .aclk(aclk), .wr_en(ks_we), .wr_addr(ks_addr), .wr_data(ks_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // last word of the round is still on the RAM output when the key is applied
    assign rk_full = {rk_reg[95:0], rd_data};

    aes_round u_round (
        .state_in(st_reg), .rkey(rk_full),
        .last(rnd_reg == 4'(aes_pkg::ROUNDS)), .state_out(round_out)
    );

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == aes_pkg::ST_IDLE) && !ks_busy;

    // round key words: request word wsel, data back next cycle
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            aes_pkg::ST_EXPAND: if (!ks_busy) state_next = aes_pkg::ST_IDLE;
            aes_pkg::ST_IDLE:   if (accept) state_next = aes_pkg::ST_ROUND;
            aes_pkg::ST_ROUND:  if (wsel_reg == 3'd4 && rnd_reg == 4'(aes_pkg::ROUNDS))
                                    state_next = aes_pkg::ST_OUT;
            aes_pkg::ST_OUT:    if (!out_valid_reg || m_ready) state_next = aes_pkg::ST_IDLE;
            default:            state_next = aes_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctr_next  = ctr_reg;
        st_next   = st_reg;
        rnd_next  = rnd_reg;
        wsel_next = wsel_reg;
        case (state_reg)
            aes_pkg::ST_IDLE: begin
                rnd_next  = '0;
                wsel_next = '0;
                if (accept) begin
                    st_next   = s_data.first_block ? {iv_hi_reg, iv_lo_reg} : ctr_reg;
                    ctr_next  = st_next + 128'd1;
                    wsel_next = 3'd1;
                end
            end
            aes_pkg::ST_ROUND: begin
                if (wsel_reg == 3'd4) begin
                    // full round key gathered; apply it
                    st_next   = (rnd_reg == 4'd0) ? (st_reg ^ rk_full) : round_out;
                    // back to round 0 after the last round so idle reads word 0
                    rnd_next  = (rnd_reg == 4'(aes_pkg::ROUNDS)) ? 4'd0 : rnd_reg + 4'd1;
                    wsel_next = 3'd0;
                end else begin
                    wsel_next = wsel_reg + 3'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= aes_pkg::ST_EXPAND;
            ctr_reg       <= '0;
            st_reg        <= '0;
            rnd_reg       <= '0;
            wsel_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            iv_hi_reg     <= '0;
            iv_lo_reg     <= '0;
        end else begin
            state_reg <= state_next;
            ctr_reg   <= ctr_next;
            st_reg    <= st_next;
            rnd_reg   <= rnd_next;
            wsel_reg  <= wsel_next;
            if (cfg_we) begin
                case (cfg_index)
                    aes_pkg::REG_KEY0:    key_reg[0] <= cfg_data;
                    aes_pkg::REG_KEY1:    key_reg[1] <= cfg_data;
                    aes_pkg::REG_KEY2:    key_reg[2] <= cfg_data;
                    aes_pkg::REG_KEY3:    key_reg[3] <= cfg_data;
                    aes_pkg::REG_IV_HIGH: iv_hi_reg  <= cfg_data;
                    aes_pkg::REG_IV_LOW:  iv_lo_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == aes_pkg::ST_OUT && (!out_valid_reg || m_ready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (accept) text_reg <= {s_data.text_high, s_data.text_low};
        // word (wsel-1) arrives now
        if (state_reg == aes_pkg::ST_ROUND && wsel_reg != 3'd0) begin
            rk_reg <= {rk_reg[95:0], rd_data};
        end
        if (state_reg == aes_pkg::ST_OUT && (!out_valid_reg || m_ready)) begin
            out_reg <= {text_reg[127:64] ^ st_reg[127:64], text_reg[63:0] ^ st_reg[63:0]};
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
endmodule

@@ design/aes_ram.sv @@
`timescale 1ns / 1ps
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

@@ design/aes_keysched.sv @@
`timescale 1ns / 1ps
// Expands the 256-bit key into round key words, one word per iteration.
// Keeps the last eight words in a shift window; writes each into the RAM.
module aes_keysched (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [255:0]             key,
    output logic                     busy,
    output logic                     wr_en,
    output logic [aes_pkg::RK_AW-1:0] wr_addr,
    output logic [31:0]              wr_data
);
    aes_pkg::ks_state_t state_reg, state_next;
    logic [31:0] win_reg [8];
    logic [31:0] win_next [8];
    logic [5:0]  idx_reg, idx_next;
    logic [7:0]  rc_reg, rc_next;
    logic [31:0] t, new_word;

    always_comb begin
        t = {win_reg[7][23:0], win_reg[7][31:24]};
        if (idx_reg[2:0] == 3'd0) begin
            new_word = win_reg[0] ^ aes_pkg::sub_word(t) ^ {rc_reg, 24'd0};
        end else if (idx_reg[2:0] == 3'd4) begin
            new_word = win_reg[0] ^ aes_pkg::sub_word(win_reg[7]);
        end else begin
            new_word = win_reg[0] ^ win_reg[7];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            aes_pkg::KS_IDLE: if (start) state_next = aes_pkg::KS_LOAD;
            aes_pkg::KS_LOAD: state_next = aes_pkg::KS_CALC;
            aes_pkg::KS_CALC: if (start) state_next = aes_pkg::KS_LOAD;
                else if (idx_reg == 6'(aes_pkg::SCHED_WORDS - 1)) state_next = aes_pkg::KS_IDLE;
            default: state_next = aes_pkg::KS_IDLE;
        endcase
    end

    always_comb begin
        win_next = win_reg;
        idx_next = idx_reg;
        rc_next  = rc_reg;
        wr_en    = 1'b0;
        wr_addr  = idx_reg;
        wr_data  = new_word;
        case (state_reg)
            aes_pkg::KS_LOAD: begin
                for (int i = 0; i < 8; i++) win_next[i] = key[255 - 32 * i -: 32];
                idx_next = 6'd0;
                rc_next  = 8'h01;
            end
            aes_pkg::KS_CALC: begin
                wr_en = 1'b1;
                if (idx_reg < 6'd8) begin
                    wr_data  = win_reg[idx_reg[2:0]];
                    idx_next = idx_reg + 6'd1;
                end else begin
                    for (int i = 0; i < 7; i++) win_next[i] = win_reg[i + 1];
                    win_next[7] = new_word;
                    idx_next = idx_reg + 6'd1;
                    if (idx_reg[2:0] == 3'd0) rc_next = aes_pkg::xtime(rc_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aes_pkg::KS_LOAD;
            idx_reg   <= '0;
            rc_reg    <= 8'h01;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rc_reg    <= rc_next;
        end
        win_reg <= win_next;
    end

    assign busy = (state_reg != aes_pkg::KS_IDLE) || start;
endmodule

@@ design/aes_round.sv @@
`timescale 1ns / 1ps
// One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
module aes_round (
    input  logic [127:0] state_in,
    input  logic [127:0] rkey,
    input  logic         last,
    output logic [127:0] state_out
);
    logic [127:0] ss;
    always_comb begin
        ss = aes_pkg::sub_shift(state_in);
        state_out = (last ? ss : aes_pkg::mix(ss)) ^ rkey;
    end
endmodule
